// File: sv/plc_pkg.sv
// Shared request codes and allocator command struct for the positional list.
package plc_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_READ    = 3'd1,
    REQ_REMOVE  = 3'd2,
    REQ_REVERSE = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_e;

  typedef struct packed {
    logic start;
    logic clr;
    logic take;
    logic rel;
  } alloc_cmd_t;

endpackage

// File: sv/plc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/plc_alloc.sv
// Free node map with a lowest-free search over groups of eight nodes.
module plc_alloc
  import plc_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int IW       = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alloc_cmd_t    cmd_i,
  input  logic [IW-1:0] take_idx_i,
  input  logic [IW-1:0] rel_idx_i,
  output logic          done_o,
  output logic [IW-1:0] idx_o
);

  localparam int GROUPS = (CAPACITY + 7) / 8;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [CAPACITY-1:0]   free_q, free_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [GW-1:0]         grp_q, grp_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [GROUPS*8-1:0]   pad;
  logic [7:0]            bits;
  logic [2:0]            enc;

  assign pad  = (GROUPS*8)'(free_q);
  assign bits = pad[grp_q*8 +: 8];

  always_comb begin
    enc = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (bits[i]) enc = 3'(i);
    end
  end

  always_comb begin
    free_d = free_q;
    busy_d = busy_q;
    done_d = 1'b0;
    grp_d  = grp_q;
    idx_d  = idx_q;
    if (cmd_i.take) free_d[take_idx_i] = 1'b0;
    if (cmd_i.rel)  free_d[rel_idx_i]  = 1'b1;
    if (cmd_i.clr)  free_d = '1;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      grp_d  = '0;
    end else if (busy_q) begin
      if (|bits) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        idx_d  = IW'({grp_q, enc});
      end else begin
        grp_d = grp_q + GW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      grp_q  <= '0;
    end else begin
      free_q <= free_d;
      busy_q <= busy_d;
      done_q <= done_d;
      grp_q  <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign done_o = done_q;
  assign idx_o  = idx_q;

endmodule

// File: sv/positional_list_with_cursor_top.sv
// Top level of the positional list: request sequencer over the node memory.
//
// Requests arrive on the s_axis channel, one transaction each; results leave
// on m_axis, exactly one per request. tuser carries the request kind
// (insert, read, remove, reverse, clear); tdata carries position and value.
// Nodes live in one memory word {value, next, prev}; accesses read the word
// through the registered RAM port, then write it back where links change.
// Steps per request, from acceptance to the result in the output register:
//   clear, refusals, unknown kinds, reverse of a short list: straight to done;
//   insert: free-map search over groups of eight, then a direct write into an
//   empty list, otherwise locate, walk and relink; read and remove: locate, walk.
// The walk follows links one at a time: from the head if the cursor is invalid;
// for a target before the cursor from the head if no farther, else the cursor;
// after it from the cursor if no farther than the tail, else from the tail.
// Reverse rewrites each node from the head with next and prev swapped.
// One request is in work at a time; a new one is accepted while a finished
// result still waits in the output register. If the receiver stalls, the
// next result is held in the sequencer until the register frees.
// Reset empties the list at once (free map in flip-flops), no clearing pass.
module positional_list_with_cursor_top
  import plc_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // position[8:0], new_value[40:9]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // ok[0], value_out[32:1], count[41:33], is_empty[42]
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = VALUE_BITS + 2 * IW;
  localparam int PW = (CW > 9) ? CW : 9;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_ALLOC  = 12'b000000000010,
    S_LOCSET = 12'b000000000100,
    S_WALK   = 12'b000000001000,
    S_GOT    = 12'b000000010000,
    S_I1     = 12'b000000100000,
    S_M1     = 12'b000001000000,
    S_M2     = 12'b000010000000,
    S_W2     = 12'b000100000000,
    S_REVS   = 12'b001000000000,
    S_REV    = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e                state_q, state_d;
  req_e                  req_q, req_d;
  logic [8:0]            pos_q, pos_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [IW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [IW-1:0]         cur_node_q, cur_node_d;
  logic [CW-1:0]         cur_pos_q, cur_pos_d;
  logic                  cur_valid_q, cur_valid_d;
  logic [IW-1:0]         node_q, node_d;
  logic [CW-1:0]         steps_q, steps_d;
  logic                  dir_q, dir_d;
  logic [IW-1:0]         nw_q, nw_d, prv_q, prv_d, nxt_q, nxt_d, wn_q, wn_d, wp_q, wp_d;
  logic                  res_ok_q, res_ok_d;
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;
  logic                  out_valid_q, out_valid_d;
  logic [47:0]           out_data_q, out_data_d;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [WW-1:0]         ram_wdata, ram_rdata;
  logic [VALUE_BITS-1:0] rd_val;
  logic [IW-1:0]         rd_next, rd_prev, wk_next;

  alloc_cmd_t            acmd;
  logic [IW-1:0]         take_idx, rel_idx, alloc_idx;
  logic                  alloc_done;

  logic                  accept;
  req_e                  in_req;
  logic [PW-1:0]         pos_x, cnt_x;
  logic [CW-1:0]         t, last, dr, de;

  plc_ram #(.WIDTH(WW), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  plc_alloc #(.CAPACITY(CAPACITY), .IW(IW)) u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (acmd),
    .take_idx_i (take_idx),
    .rel_idx_i  (rel_idx),
    .done_o     (alloc_done),
    .idx_o      (alloc_idx)
  );

  assign rd_val  = ram_rdata[WW-1 -: VALUE_BITS];
  assign rd_next = ram_rdata[2*IW-1 -: IW];
  assign rd_prev = ram_rdata[IW-1:0];
  assign wk_next = dir_q ? rd_prev : rd_next;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_req        = req_e'(s_axis_tuser);
  assign pos_x         = PW'(s_axis_tdata[8:0]);
  assign cnt_x         = PW'(cnt_q);
  assign t             = CW'(pos_q);
  assign last          = cnt_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pos_d       = pos_q;
    val_d       = val_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    cur_node_d  = cur_node_q;
    cur_pos_d   = cur_pos_q;
    cur_valid_d = cur_valid_q;
    node_d      = node_q;
    steps_d     = steps_q;
    dir_d       = dir_q;
    nw_d        = nw_q;
    prv_d       = prv_q;
    nxt_d       = nxt_q;
    wn_d        = wn_q;
    wp_d        = wp_q;
    res_ok_d    = res_ok_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = '0;
    ram_raddr   = node_q;
    acmd        = '0;
    take_idx    = nw_q;
    rel_idx     = node_q;
    dr          = '0;
    de          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d     = in_req;
          pos_d     = s_axis_tdata[8:0];
          val_d     = VALUE_BITS'($unsigned(s_axis_tdata[40:9]));
          res_ok_d  = 1'b0;
          res_val_d = '0;
          state_d   = S_DONE;
          unique case (in_req)
            REQ_INSERT: begin
              if (pos_x <= cnt_x && cnt_x < PW'(CAPACITY)) begin
                acmd.start = 1'b1;
                state_d    = S_ALLOC;
              end
            end
            REQ_READ, REQ_REMOVE: begin
              if (pos_x < cnt_x) state_d = S_LOCSET;
            end
            REQ_REVERSE: begin
              res_ok_d = 1'b1;
              if (cnt_q > CW'(1)) state_d = S_REVS;
            end
            REQ_CLEAR: begin
              res_ok_d    = 1'b1;
              acmd.clr    = 1'b1;
              head_d      = '0;
              tail_d      = '0;
              cnt_d       = '0;
              cur_node_d  = '0;
              cur_pos_d   = '0;
              cur_valid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_ALLOC: begin
        if (alloc_done) begin
          nw_d = alloc_idx;
          if (cnt_q == '0) begin
            ram_we      = 1'b1;
            ram_waddr   = alloc_idx;
            ram_wdata   = {val_q, {IW{1'b0}}, {IW{1'b0}}};
            acmd.take   = 1'b1;
            take_idx    = alloc_idx;
            head_d      = alloc_idx;
            tail_d      = alloc_idx;
            cnt_d       = CW'(1);
            cur_node_d  = alloc_idx;
            cur_pos_d   = '0;
            cur_valid_d = 1'b1;
            res_ok_d    = 1'b1;
            state_d     = S_DONE;
          end else begin
            state_d = S_LOCSET;
          end
        end
      end

      S_LOCSET: begin
        state_d = S_GOT;
        if (req_q == REQ_INSERT && t == '0) begin
          node_d = head_q;
        end else if (req_q == REQ_INSERT && t == cnt_q) begin
          node_d = tail_q;
        end else if (t == '0) begin
          node_d = head_q;
        end else if (t == last) begin
          node_d = tail_q;
        end else if (cur_valid_q && t == cur_pos_q) begin
          node_d = cur_node_q;
        end else begin
          state_d = S_WALK;
          if (!cur_valid_q) begin
            node_d = head_q; dir_d = 1'b0; steps_d = t;
          end else if (t < cur_pos_q) begin
            dr = cur_pos_q - t;
            if (t <= dr) begin
              node_d = head_q; dir_d = 1'b0; steps_d = t;
            end else begin
              node_d = cur_node_q; dir_d = 1'b1; steps_d = dr;
            end
          end else begin
            dr = t - cur_pos_q;
            de = last - t;
            if (dr <= de) begin
              node_d = cur_node_q; dir_d = 1'b0; steps_d = dr;
            end else begin
              node_d = tail_q; dir_d = 1'b1; steps_d = de;
            end
          end
        end
        ram_raddr = node_d;
      end

      S_WALK: begin
        ram_raddr = wk_next;
        steps_d   = steps_q - CW'(1);
        if (steps_q == CW'(1)) begin
          node_d      = wk_next;
          cur_node_d  = wk_next;
          cur_pos_d   = t;
          cur_valid_d = 1'b1;
          state_d     = S_GOT;
        end
      end

      S_GOT: begin
        state_d = S_DONE;
        unique case (req_q)
          REQ_READ: begin
            res_ok_d  = 1'b1;
            res_val_d = rd_val;
          end
          REQ_REMOVE: begin
            res_ok_d  = 1'b1;
            res_val_d = rd_val;
            acmd.rel  = 1'b1;
            cnt_d     = last;
            if (t == '0) begin
              if (cnt_q == CW'(1)) begin
                head_d      = '0;
                tail_d      = '0;
                cur_node_d  = '0;
                cur_pos_d   = '0;
                cur_valid_d = 1'b0;
              end else begin
                head_d      = rd_next;
                cur_node_d  = rd_next;
                cur_pos_d   = '0;
                cur_valid_d = 1'b1;
              end
            end else begin
              cur_node_d  = rd_prev;
              cur_pos_d   = t - CW'(1);
              cur_valid_d = 1'b1;
              if (t == last) begin
                tail_d = rd_prev;
              end else begin
                prv_d     = rd_prev;
                nxt_d     = rd_next;
                ram_raddr = rd_prev;
                state_d   = S_M1;
              end
            end
          end
          default: begin
            ram_we = 1'b1;
            if (t == '0) begin
              ram_wdata = {rd_val, rd_next, nw_q};
              wn_d      = node_q;
              wp_d      = '0;
              head_d    = nw_q;
              state_d   = S_W2;
            end else if (t == cnt_q) begin
              ram_wdata = {rd_val, nw_q, rd_prev};
              wn_d      = '0;
              wp_d      = node_q;
              tail_d    = nw_q;
              state_d   = S_W2;
            end else begin
              ram_wdata = {rd_val, rd_next, nw_q};
              wn_d      = node_q;
              wp_d      = rd_prev;
              ram_raddr = rd_prev;
              state_d   = S_I1;
            end
          end
        endcase
      end

      S_I1: begin
        ram_we    = 1'b1;
        ram_waddr = wp_q;
        ram_wdata = {rd_val, nw_q, rd_prev};
        state_d   = S_W2;
      end

      S_W2: begin
        ram_we      = 1'b1;
        ram_waddr   = nw_q;
        ram_wdata   = {val_q, wn_q, wp_q};
        acmd.take   = 1'b1;
        cnt_d       = cnt_q + CW'(1);
        cur_node_d  = nw_q;
        cur_pos_d   = t;
        cur_valid_d = 1'b1;
        res_ok_d    = 1'b1;
        state_d     = S_DONE;
      end

      S_M1: begin
        ram_we    = 1'b1;
        ram_waddr = prv_q;
        ram_wdata = {rd_val, nxt_q, rd_prev};
        ram_raddr = nxt_q;
        state_d   = S_M2;
      end

      S_M2: begin
        ram_we    = 1'b1;
        ram_waddr = nxt_q;
        ram_wdata = {rd_val, rd_next, prv_q};
        state_d   = S_DONE;
      end

      S_REVS: begin
        ram_raddr = head_q;
        node_d    = head_q;
        steps_d   = cnt_q;
        state_d   = S_REV;
      end

      S_REV: begin
        ram_we    = 1'b1;
        ram_wdata = {rd_val, rd_prev, rd_next};
        ram_raddr = rd_next;
        node_d    = rd_next;
        steps_d   = steps_q - CW'(1);
        if (steps_q == CW'(1)) begin
          head_d      = tail_q;
          tail_d      = head_q;
          cur_node_d  = '0;
          cur_pos_d   = '0;
          cur_valid_d = 1'b0;
          state_d     = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, (cnt_q == '0), 9'(cnt_q), 32'(res_val_q), res_ok_q};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      cur_node_q  <= '0;
      cur_pos_q   <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      cur_node_q  <= cur_node_d;
      cur_pos_q   <= cur_pos_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    node_q     <= node_d;
    steps_q    <= steps_d;
    dir_q      <= dir_d;
    nw_q       <= nw_d;
    prv_q      <= prv_d;
    nxt_q      <= nxt_d;
    wn_q       <= wn_d;
    wp_q       <= wp_d;
    res_ok_q   <= res_ok_d;
    res_val_q  <= res_val_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty list with stale head or tail");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_pos_q < cnt_q))
    else $error("cursor beyond list end");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done state");

endmodule

// File: sim/positional_list_with_cursor_top_tb.sv
// Self-checking testbench for the positional list: directed and random requests against a queue predictor.
module positional_list_with_cursor_top_tb
  import plc_pkg::*;
();

  localparam int CAP = 256;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM = 700;

  typedef struct packed {
    logic        is_empty;
    logic [8:0]  count;
    logic [31:0] value_out;
    logic        ok;
  } list_resp_t;

  class list_scoreboard;
    logic [31:0] contents[$];
    list_resp_t  pending[$];
    int          errors;

    function void note_request(logic [2:0] kind, logic [8:0] pos, logic [31:0] val);
      list_resp_t r;
      r = '0;
      case (kind)
        REQ_INSERT: begin
          if (pos <= contents.size() && contents.size() < CAP) begin
            contents.insert(pos, val);
            r.ok = 1'b1;
          end
        end
        REQ_READ: begin
          if (pos < contents.size()) begin
            r.value_out = contents[pos];
            r.ok = 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (pos < contents.size()) begin
            r.value_out = contents[pos];
            contents.delete(pos);
            r.ok = 1'b1;
          end
        end
        REQ_REVERSE: begin
          contents.reverse();
          r.ok = 1'b1;
        end
        REQ_CLEAR: begin
          contents.delete();
          r.ok = 1'b1;
        end
        default: ;
      endcase
      r.count = 9'(contents.size());
      r.is_empty = (contents.size() == 0);
      pending.push_back(r);
    endfunction

    task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task automatic check_result(logic [47:0] data);
      list_resp_t got, want;
      got = data[42:0];
      if (pending.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending.pop_front();
        if (data[47:43] != 0) report("padding bits set");
        if (got.ok !== want.ok) report($sformatf("ok %0b want %0b", got.ok, want.ok));
        if (got.value_out !== want.value_out)
          report($sformatf("value %h want %h", got.value_out, want.value_out));
        if (got.count !== want.count)
          report($sformatf("count %0d want %0d", got.count, want.count));
        if (got.is_empty !== want.is_empty)
          report($sformatf("empty %0b want %0b", got.is_empty, want.is_empty));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  list_scoreboard sb;
  int idle_cycles;
  int stall_mode;

  positional_list_with_cursor_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver stall pattern, changes mode every so often
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_mode    <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("positional_list_with_cursor_top_tb failed");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] kind, logic [8:0] pos, logic [31:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, val, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(kind, pos, val);
  endtask

  task automatic pause_sender(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [8:0] pick_pos();
    int n;
    n = sb.contents.size();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'(n);
      2: return 9'($urandom_range(0, 511));
      3: return (n > 0) ? 9'(n - 1) : 9'd0;
      default: return 9'($urandom_range(0, n));
    endcase
  endfunction

  task automatic random_request(int fill_bias);
    int sel;
    logic [2:0] kind;
    sel = $urandom_range(0, 99);
    if (sel < fill_bias)       kind = REQ_INSERT;
    else if (sel < 70)         kind = REQ_READ;
    else if (sel < 88)         kind = REQ_REMOVE;
    else if (sel < 95)         kind = REQ_REVERSE;
    else if (sel < 97)         kind = REQ_CLEAR;
    else                       kind = 3'($urandom_range(5, 7));
    send_request(kind, pick_pos(), $urandom());
  endtask

  initial begin
    int burst;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    sb = new();
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: empty list refusals, extremes, every request kind
    send_request(REQ_READ, 9'd0, 32'h0);
    send_request(REQ_REMOVE, 9'd0, 32'h0);
    send_request(REQ_INSERT, 9'd1, 32'h1);
    send_request(REQ_REVERSE, 9'd0, 32'h0);
    send_request(REQ_INSERT, 9'd0, 32'h7fffffff);
    send_request(REQ_REVERSE, 9'd0, 32'h0);
    send_request(REQ_INSERT, 9'd1, 32'h80000000);
    send_request(REQ_INSERT, 9'd1, 32'hffffffff);
    send_request(REQ_INSERT, 9'd0, 32'h00000000);
    send_request(REQ_INSERT, 9'd2, 32'ha5a5a5a5);
    send_request(REQ_READ, 9'd2, 32'h0);
    send_request(REQ_READ, 9'd4, 32'h0);
    send_request(REQ_READ, 9'd5, 32'h0);
    send_request(REQ_REVERSE, 9'd0, 32'h0);
    send_request(REQ_READ, 9'd1, 32'h0);
    send_request(REQ_REMOVE, 9'd2, 32'h0);
    send_request(REQ_REMOVE, 9'd3, 32'h0);
    send_request(REQ_REMOVE, 9'd0, 32'h0);
    send_request(3'd5, 9'd511, 32'h0);
    send_request(3'd7, 9'd0, 32'h0);
    send_request(REQ_CLEAR, 9'd0, 32'h0);
    send_request(REQ_INSERT, 9'd0, 32'h5a5a5a5a);
    drain_results();
    // fill to capacity, then probe the full list
    while (sb.contents.size() < CAP)
      send_request(REQ_INSERT, 9'($urandom_range(0, sb.contents.size())), $urandom());
    send_request(REQ_INSERT, 9'd0, 32'h1234);
    send_request(REQ_INSERT, 9'd256, 32'h1234);
    send_request(REQ_READ, 9'd255, 32'h0);
    send_request(REQ_READ, 9'd256, 32'h0);
    send_request(REQ_READ, 9'd128, 32'h0);
    send_request(REQ_REVERSE, 9'd0, 32'h0);
    send_request(REQ_READ, 9'd200, 32'h0);
    send_request(REQ_REMOVE, 9'd255, 32'h0);
    drain_results();
    // random phase with bursts and gaps; mostly short lists
    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && i < N_RANDOM; j++, i++) begin
        if (sb.contents.size() > 48 && $urandom_range(0, 3) == 0)
          random_request(5);
        else
          random_request(40);
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 30));
      if ($urandom_range(0, 29) == 0) drain_results();
    end
    drain_results();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("positional_list_with_cursor_top_tb passed");
    end else begin
      $display("positional_list_with_cursor_top_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/plc_pkg.sv
sv/plc_ram.sv
sv/plc_alloc.sv
sv/positional_list_with_cursor_top.sv
sim/positional_list_with_cursor_top_tb.sv
